/* rtl/light_effect_sequencer_top_defines.svh */
// Assertion macros shared by the checker of the light effect sequencer.
// Depends on nothing; included by the checker file only.
`ifndef LIGHT_EFFECT_SEQUENCER_TOP_DEFINES_SVH
`define LIGHT_EFFECT_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define LFS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LFS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lfs_pkg.sv */
// Types, constants, pattern table and helper functions of the light effect sequencer.
// Depends on nothing; imported by the channel update logic and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lfs_pkg;

    localparam int CFG_REGS      = 7;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_W         = 8;
    localparam int REQ_W         = 12;
    localparam int OUTPUT_COUNT  = 12;
    localparam int PATTERN_STEPS = 8;
    localparam int STEP_W        = 3;
    localparam int PATTERN_COUNT = 16;
    localparam int PAT_W         = 4;
    localparam int CNT_W         = 6;
    localparam int LEVEL_W       = 2;

    localparam int CFG_BIT_NEED_F0     = 5;
    localparam int CFG_BIT_DIRECTION   = 6;
    localparam int CFG_BIT_DIRECTIONAL = 7;

    localparam logic [LEVEL_W-1:0] LV_ON = 2'b10;

    typedef logic [CFG_W-1:0] t_cfg;

    typedef struct packed {
        logic              held;
        logic [STEP_W-1:0] step;
        logic [CNT_W-1:0]  count;
    } t_chan_state;

    typedef struct packed {
        t_cfg cfg;
        logic want;
        logic f0;
        logic dir;
    } t_chan_req;

    localparam logic [7:0] PATTERNS [PATTERN_COUNT][PATTERN_STEPS] = '{
        '{8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF},
        '{8'h85, 8'h70, 8'h85, 8'hF0, 8'h85, 8'h70, 8'hB0, 8'hF0},
        '{8'h82, 8'h30, 8'h83, 8'h05, 8'h85, 8'h3F, 8'h82, 8'h3F},
        '{8'hBF, 8'h3F, 8'hBF, 8'h3F, 8'hBF, 8'h3F, 8'hBF, 8'h3F},
        '{8'h81, 8'h3F, 8'h81, 8'h3F, 8'h81, 8'h3F, 8'h81, 8'h3F},
        '{8'h81, 8'h02, 8'h81, 8'h3F, 8'h81, 8'h02, 8'h81, 8'h3F},
        '{8'h82, 8'h45, 8'hC5, 8'h25, 8'hC5, 8'h45, 8'h82, 8'h82},
        '{8'h85, 8'h55, 8'h85, 8'h55, 8'h85, 8'h55, 8'h95, 8'h55},
        '{8'hB0, 8'h30, 8'hB0, 8'h30, 8'hB0, 8'h30, 8'hB0, 8'h30},
        '{8'h30, 8'hB0, 8'h30, 8'hB0, 8'h30, 8'hB0, 8'h30, 8'hB0},
        '{8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F},
        '{8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F},
        '{8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F},
        '{8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F},
        '{8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F},
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}
    };

    function automatic logic [7:0] pattern_entry(input logic [PAT_W-1:0]  pat,
                                                 input logic [STEP_W-1:0] step);
        return PATTERNS[pat][step];
    endfunction

    function automatic logic [STEP_W-1:0] next_step(input logic [STEP_W-1:0] step);
        if (step == STEP_W'(PATTERN_STEPS - 1)) begin
            return '0;
        end
        return step + 1'b1;
    endfunction

endpackage

`default_nettype wire

/* rtl/light_effect_sequencer_top.sv */
// Top level of the light effect sequencer: channel sequencer, state RAM and result register.
// Depends on lfs_pkg, lfs_ram and lfs_chan_update.
`timescale 1ns / 1ps
`default_nettype none

// Each tick beat is worked through one effect channel per cycle, but a tick's last channel waits
// while the output register cannot take its result: the channel's state is read from a small
// RAM, updated and written back in the following cycle. A result passes the update stage
// register into the output register. The next tick is accepted once the last channel of the
// previous one is issued, also while its result still waits there. Configuration writes are
// taken in every cycle and should only be issued while no tick is in progress.
module light_effect_sequencer_top
    import lfs_pkg::*;
#(
    parameter int EFFECT_CHANNELS = 7
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [REQ_W-1:0]     i_function_requests,
    input  wire logic                 i_travel_direction,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [OUTPUT_COUNT-1:0]   o_output_levels,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam int CH_W = (EFFECT_CHANNELS > 1) ? $clog2(EFFECT_CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(EFFECT_CHANNELS - 1);

    t_cfg r_cfg [CFG_REGS];

    logic             r_busy;
    logic [CH_W-1:0]  r_ch;
    logic [REQ_W-1:0] r_req;
    logic             r_dir;

    logic                       r_b_valid;
    logic [CH_W-1:0]            r_b_ch;
    logic                       r_b_last;
    t_chan_req                  r_b_ctl;
    logic [REQ_W-1:0]           r_b_req;
    logic                       r_b_vld;
    logic                       r_fwd_hit;
    t_chan_state                r_fwd_data;
    logic [EFFECT_CHANNELS-1:0] r_valid;
    logic [EFFECT_CHANNELS-1:0] r_acc;
    logic                       r_out_valid;
    logic [OUTPUT_COUNT-1:0]    r_out_levels;

    logic                       last_issue;
    logic                       out_free;
    logic                       issue_fire;
    logic                       done_issue;
    logic                       in_fire;
    logic [REQ_W-1:0]           req_sh;
    t_cfg                       sel_cfg;
    t_chan_req                  issue_ctl;
    logic [$bits(t_chan_state)-1:0] ram_rdata;
    t_chan_state                cur_state;
    t_chan_state                upd_state;
    logic                       level;
    logic [EFFECT_CHANNELS-1:0] acc_next;
    logic [OUTPUT_COUNT-1:0]    n_levels;

    assign last_issue = (r_ch == LAST_CH);
    assign out_free   = !(r_b_valid && r_b_last) && (!r_out_valid || i_out_ready);
    assign issue_fire = r_busy && (!last_issue || out_free);
    assign done_issue = issue_fire && last_issue;
    assign o_in_ready = !r_busy || done_issue;
    assign in_fire    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CFG_REGS; k++) begin
                r_cfg[k] <= '0;
            end
        end else if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(CFG_REGS))) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    always_comb begin
        sel_cfg = '0;
        for (int k = 0; k < CFG_REGS; k++) begin
            if ((k < EFFECT_CHANNELS) && (r_ch == CH_W'(k))) begin
                sel_cfg = r_cfg[k];
            end
        end
    end

    assign req_sh         = r_req >> r_ch;
    assign issue_ctl.cfg  = sel_cfg;
    assign issue_ctl.want = req_sh[0];
    assign issue_ctl.f0   = r_req[0];
    assign issue_ctl.dir  = r_dir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ch   <= '0;
        end else if (in_fire) begin
            r_busy <= 1'b1;
            r_ch   <= '0;
        end else if (done_issue) begin
            r_busy <= 1'b0;
        end else if (issue_fire) begin
            r_ch   <= r_ch + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_req <= i_function_requests;
            r_dir <= i_travel_direction;
        end
    end

    lfs_ram #(
        .WIDTH ($bits(t_chan_state)),
        .DEPTH (EFFECT_CHANNELS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (r_b_valid),
        .i_waddr (r_b_ch),
        .i_wdata (upd_state),
        .i_re    (issue_fire),
        .i_raddr (r_ch),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_fwd_hit <= 1'b0;
            r_valid   <= '0;
        end else begin
            r_b_valid <= issue_fire;
            r_fwd_hit <= issue_fire && r_b_valid && (r_b_ch == r_ch);
            if (r_b_valid) begin
                r_valid[r_b_ch] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue_fire) begin
            r_b_ch   <= r_ch;
            r_b_last <= last_issue;
            r_b_ctl  <= issue_ctl;
            r_b_req  <= r_req;
            r_b_vld  <= r_valid[r_ch];
        end
        r_fwd_data <= upd_state;
    end

    always_comb begin
        if (r_fwd_hit) begin
            cur_state = r_fwd_data;
        end else if (r_b_vld) begin
            cur_state = t_chan_state'(ram_rdata);
        end else begin
            cur_state = '0;
        end
    end

    lfs_chan_update u_chan_update (
        .i_req   (r_b_ctl),
        .i_state (cur_state),
        .o_state (upd_state),
        .o_level (level)
    );

    if (EFFECT_CHANNELS > 1) begin : g_acc_multi
        assign acc_next = {level, r_acc[EFFECT_CHANNELS-1:1]};
    end else begin : g_acc_single
        assign acc_next = level;
    end

    for (genvar i = 0; i < OUTPUT_COUNT; i++) begin : g_levels
        if (i < EFFECT_CHANNELS) begin : g_effect
            assign n_levels[i] = acc_next[i];
        end else begin : g_direct
            assign n_levels[i] = r_b_req[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_acc <= acc_next;
        end
        if (r_b_valid && r_b_last) begin
            r_out_levels <= n_levels;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_b_valid && r_b_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_output_levels = r_out_levels;

endmodule

`default_nettype wire

/* rtl/lfs_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; holds the per-channel sequencer state.
`timescale 1ns / 1ps
`default_nettype none

module lfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/lfs_chan_update.sv */
// Next-state logic of one effect channel: enable, countdown and pattern stepping.
// Depends on lfs_pkg for the state types and the pattern table.
`timescale 1ns / 1ps
`default_nettype none

module lfs_chan_update
    import lfs_pkg::*;
(
    input  wire t_chan_req   i_req,
    input  wire t_chan_state i_state,
    output t_chan_state      o_state,
    output logic             o_level
);

    logic              dir_ok;
    logic              f0_ok;
    logic              enable;
    logic [STEP_W-1:0] step_next;
    logic [7:0]        entry;

    assign dir_ok    = !i_req.cfg[CFG_BIT_DIRECTIONAL]
                       || (i_req.dir == i_req.cfg[CFG_BIT_DIRECTION]);
    assign f0_ok     = !i_req.cfg[CFG_BIT_NEED_F0] || i_req.f0;
    assign enable    = i_req.want && dir_ok && f0_ok;
    assign step_next = next_step(i_state.step);
    assign entry     = pattern_entry(i_req.cfg[PAT_W-1:0], step_next);

    always_comb begin
        if (!enable) begin
            o_state = '0;
        end else if (i_state.count != '0) begin
            o_state       = i_state;
            o_state.count = i_state.count - CNT_W'(1);
        end else begin
            o_state.held  = (entry[7:6] == LV_ON);
            o_state.step  = step_next;
            o_state.count = entry[CNT_W-1:0];
        end
    end

    assign o_level = o_state.held;

endmodule

`default_nettype wire

/* rtl/lfs_checker.sv */
// Port-level checker for the light effect sequencer and its bind to the top level.
// Depends on light_effect_sequencer_top_defines.svh for the assertion macros.
`timescale 1ns / 1ps
`default_nettype none

`include "light_effect_sequencer_top_defines.svh"

module lfs_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        o_in_ready,
    input  wire logic        o_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [11:0] o_output_levels
);

    logic [2:0] r_pending;
    logic [2:0] n_pending;

    always_comb begin
        n_pending = r_pending;
        if (i_in_valid && o_in_ready) begin
            n_pending = n_pending + 3'd1;
        end
        if (o_out_valid && i_out_ready) begin
            n_pending = n_pending - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    `LFS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_output_levels), "result beat changed while stalled")
    `LFS_ASSERT_IMP(a_no_spurious, i_clk, i_rst_n, o_out_valid,
        r_pending != 3'd0, "result beat without an outstanding tick")
    `LFS_ASSERT_IMP(a_ready_when_empty, i_clk, i_rst_n, r_pending == 3'd0,
        o_in_ready, "input not ready while no tick is outstanding")
    `LFS_ASSERT_IMP(a_bounded, i_clk, i_rst_n, 1'b1,
        r_pending <= 3'd3, "more ticks in flight than the pipeline holds")

endmodule

bind light_effect_sequencer_top lfs_checker u_lfs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_output_levels (o_output_levels)
);

`default_nettype wire
